// ===== sv/tgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tgr_pkg
// shared types and constants of the touch gesture recognizer
// ----------------------------------------------------------------------------
`default_nettype none

package tgr_pkg;

	localparam int AREA_SLOTS     = 8;
	localparam int AREA_COUNT_DEF = 8;
	localparam int AREA_HEIGHT    = 35;

	localparam logic [8:0] AREA_LEFT [AREA_SLOTS] = '{
		9'd10, 9'd115, 9'd220, 9'd10, 9'd115, 9'd220, 9'd10, 9'd115
	};
	localparam logic [7:0] AREA_TOP [AREA_SLOTS] = '{
		8'd35, 8'd35, 8'd35, 8'd85, 8'd85, 8'd85, 8'd135, 8'd135
	};

	localparam logic signed [3:0] AREA_NONE = -4'sd1;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_MOVE_THRESHOLD  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_TIME = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_TAP_TIME = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_AREA_WIDTH      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SWIPE_DISTANCE  = 3'd4;

	localparam logic [7:0]  MOVE_THRESHOLD_RST  = 8'd5;
	localparam logic [15:0] LONG_PRESS_TIME_RST = 16'd1000;
	localparam logic [15:0] DOUBLE_TAP_TIME_RST = 16'd300;
	localparam logic [8:0]  AREA_WIDTH_RST      = 9'd95;
	localparam logic [8:0]  SWIPE_DISTANCE_RST  = 9'd50;

	typedef enum logic [3:0] {
		EV_NONE        = 4'd0,
		EV_DOWN        = 4'd1,
		EV_MOVE        = 4'd2,
		EV_UP          = 4'd3,
		EV_LONG        = 4'd4,
		EV_DOUBLE_TAP  = 4'd5,
		EV_SWIPE_LEFT  = 4'd6,
		EV_SWIPE_RIGHT = 4'd7,
		EV_SWIPE_UP    = 4'd8,
		EV_SWIPE_DOWN  = 4'd9
	} event_kind_t;

	typedef struct packed {
		logic [8:0] x;
		logic [7:0] y;
	} point_t;

	typedef struct packed {
		logic        touched;
		logic [11:0] raw_x;
		logic [11:0] raw_y;
		logic [31:0] now_ms;
	} sample_t;

	typedef struct packed {
		event_kind_t      event_kind;
		logic [8:0]       point_x;
		logic [7:0]       point_y;
		logic [8:0]       origin_x;
		logic [7:0]       origin_y;
		logic signed [3:0] area_hit;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/tgr_calib.sv =====
// ----------------------------------------------------------------------------
// tgr_calib
// maps a raw controller point to display pixels, axes swapped and clamped
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_calib import tgr_pkg::*; (
	input  logic [11:0] raw_x,
	input  logic [11:0] raw_y,
	output point_t      pt
);

	// lower segment: e*160/141 as multiply by 2^22/141 rounded up
	localparam logic [29:0] RECIP_141 = 30'd29747;
	localparam int          SHIFT_141 = 22;
	// upper segment: d*16/15 = d + d/15, d/15 as multiply by 137 >> 11
	localparam logic [15:0] RECIP_15  = 16'd137;
	localparam int          SHIFT_15  = 11;

	logic [7:0]  e_lo;
	logic [29:0] prod_lo;
	logic [7:0]  d_hi;
	logic [15:0] prod_hi;
	logic [3:0]  frac_hi;

	assign e_lo    = 8'(raw_y - 12'd9);
	assign prod_lo = 30'({e_lo, 7'd0} + {2'd0, e_lo, 5'd0}) * RECIP_141;
	assign d_hi    = 8'(raw_y - 12'd150);
	assign prod_hi = 16'(d_hi) * RECIP_15;
	assign frac_hi = 4'(prod_hi >> SHIFT_15);

	always_comb begin
		if (raw_y >= 12'd300) begin
			pt.x = 9'd319;
		end else if (raw_y > 12'd150) begin
			pt.x = 9'd160 + 9'(d_hi) + 9'(frac_hi);
		end else if (raw_y < 12'd9) begin
			pt.x = 9'd0;
		end else begin
			pt.x = 9'(prod_lo >> SHIFT_141);
		end

		if (raw_x >= 12'd240) begin
			pt.y = 8'd0;
		end else if (raw_x == 12'd0) begin
			pt.y = 8'd239;
		end else begin
			pt.y = 8'(12'd240 - raw_x);
		end
	end

endmodule

`default_nettype wire

// ===== sv/tgr_area.sv =====
// ----------------------------------------------------------------------------
// tgr_area
// finds the first hit rectangle that contains a point
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_area import tgr_pkg::*; #(
	parameter int AREA_COUNT = AREA_COUNT_DEF
) (
	input  point_t            pt,
	input  logic [8:0]        area_width,
	output logic signed [3:0] area_hit
);

	logic [AREA_COUNT-1:0] hit;

	always_comb begin
		for (int i = 0; i < AREA_COUNT; i++) begin
			hit[i] = (pt.x >= AREA_LEFT[i])
				&& ({1'b0, pt.x} < ({1'b0, AREA_LEFT[i]} + {1'b0, area_width}))
				&& (pt.y >= AREA_TOP[i])
				&& ({1'b0, pt.y} < ({1'b0, AREA_TOP[i]} + 9'(AREA_HEIGHT)));
		end
	end

	// lowest index wins
	always_comb begin
		area_hit = AREA_NONE;
		for (int i = AREA_COUNT - 1; i >= 0; i--) begin
			if (hit[i]) begin
				area_hit = signed'(4'(i));
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/touch_gesture_recognizer.sv =====
// ----------------------------------------------------------------------------
// touch_gesture_recognizer
// turns polled touch samples into one gesture event per sample
// ----------------------------------------------------------------------------
// channel   dir  handshake                  payload
// sample    in   sample_valid/sample_ready  sample_data (sample_t)
// result    out  result_valid/result_ready  result_data (result_t)
// cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// one sample per cycle while the result is not stalled; a request accepted into
// the input register moves on to the result register, gesture logic between
// the two; the press state updates as the sample leaves the input register
// a stalled result holds the input register; sample_ready drops only then
// reset clears the press state and loads the register defaults; cfg_ready
// is always high
// ----------------------------------------------------------------------------
`default_nettype none

module touch_gesture_recognizer import tgr_pkg::*; #(
	parameter int AREA_COUNT = AREA_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  sample_t                sample_data,
	output logic                   result_valid,
	input  logic                   result_ready,
	output result_t                result_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [7:0]  move_threshold_q;
	logic [15:0] long_press_time_q;
	logic [15:0] double_tap_time_q;
	logic [8:0]  area_width_q;
	logic [8:0]  swipe_distance_q;

	logic        is_pressed_q, long_done_q, tap_pending_q;
	point_t      begin_q, now_q;
	logic [31:0] press_time_q, event_time_q;

	logic        is_pressed_n, long_done_n, tap_pending_n;
	point_t      begin_n, now_n;
	logic [31:0] press_time_n, event_time_n;

	sample_t     sample_s1;
	logic        valid_s1;
	result_t     result_q;
	logic        result_valid_q;
	logic        advance;

	point_t            cal_pt;
	logic signed [3:0] hit;
	event_kind_t       kind;
	logic [8:0]        dx, ax;
	logic [7:0]        dy, ay;
	logic [31:0]       t;
	logic [31:0]       dur;

	assign advance      = !result_valid_q || result_ready;
	assign sample_ready = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result_data  = result_q;
	assign cfg_ready    = 1'b1;

	tgr_calib u_calib (
		.raw_x (sample_s1.raw_x),
		.raw_y (sample_s1.raw_y),
		.pt    (cal_pt)
	);

	tgr_area #(
		.AREA_COUNT (AREA_COUNT)
	) u_area (
		.pt         (now_n),
		.area_width (area_width_q),
		.area_hit   (hit)
	);

	assign t   = sample_s1.now_ms;
	assign dur = t - press_time_q;
	assign dx  = (cal_pt.x > now_q.x) ? cal_pt.x - now_q.x : now_q.x - cal_pt.x;
	assign dy  = (cal_pt.y > now_q.y) ? cal_pt.y - now_q.y : now_q.y - cal_pt.y;
	assign ax  = (now_q.x > begin_q.x) ? now_q.x - begin_q.x : begin_q.x - now_q.x;
	assign ay  = (now_q.y > begin_q.y) ? now_q.y - begin_q.y : begin_q.y - now_q.y;

	always_comb begin
		is_pressed_n  = is_pressed_q;
		long_done_n   = long_done_q;
		tap_pending_n = tap_pending_q;
		begin_n       = begin_q;
		now_n         = now_q;
		press_time_n  = press_time_q;
		event_time_n  = event_time_q;
		kind          = EV_NONE;

		if (sample_s1.touched) begin
			if (!is_pressed_q) begin
				is_pressed_n = 1'b1;
				begin_n      = cal_pt;
				now_n        = cal_pt;
				press_time_n = t;
				event_time_n = t;
				long_done_n  = 1'b0;
				kind         = EV_DOWN;
			end else begin
				if (dx > 9'(move_threshold_q) || dy > move_threshold_q) begin
					now_n        = cal_pt;
					event_time_n = t;
					kind         = EV_MOVE;
				end
				if (!long_done_q && dur > 32'(long_press_time_q)) begin
					long_done_n = 1'b1;
					kind        = EV_LONG;
				end
			end
		end else if (is_pressed_q) begin
			is_pressed_n = 1'b0;
			if (long_done_q) begin
				kind = EV_UP;
			end else if (dur < 32'(double_tap_time_q)) begin
				if (tap_pending_q && (t - event_time_q) < 32'(double_tap_time_q)) begin
					kind          = EV_DOUBLE_TAP;
					tap_pending_n = 1'b0;
				end else begin
					tap_pending_n = 1'b1;
					event_time_n  = t;
					kind          = EV_UP;
				end
			end else if (ax < swipe_distance_q && 9'(ay) < swipe_distance_q) begin
				kind = EV_UP;
			end else if (ax > 9'(ay)) begin
				kind = (now_q.x > begin_q.x) ? EV_SWIPE_RIGHT : EV_SWIPE_LEFT;
			end else begin
				kind = (now_q.y > begin_q.y) ? EV_SWIPE_DOWN : EV_SWIPE_UP;
			end
		end

		// tap timeout
		if (tap_pending_n && (t - event_time_n) > 32'(double_tap_time_q)) begin
			tap_pending_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (sample_ready) begin
				valid_s1 <= sample_valid;
			end
			if (advance) begin
				result_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			sample_s1 <= sample_data;
		end
		if (advance && valid_s1) begin
			result_q.event_kind <= kind;
			if (kind == EV_NONE) begin
				result_q.point_x  <= '0;
				result_q.point_y  <= '0;
				result_q.origin_x <= '0;
				result_q.origin_y <= '0;
				result_q.area_hit <= AREA_NONE;
			end else begin
				result_q.point_x  <= now_n.x;
				result_q.point_y  <= now_n.y;
				result_q.origin_x <= begin_n.x;
				result_q.origin_y <= begin_n.y;
				result_q.area_hit <= hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_pressed_q  <= 1'b0;
			long_done_q   <= 1'b0;
			tap_pending_q <= 1'b0;
			begin_q       <= '0;
			now_q         <= '0;
			press_time_q  <= '0;
			event_time_q  <= '0;
		end else if (advance && valid_s1) begin
			is_pressed_q  <= is_pressed_n;
			long_done_q   <= long_done_n;
			tap_pending_q <= tap_pending_n;
			begin_q       <= begin_n;
			now_q         <= now_n;
			press_time_q  <= press_time_n;
			event_time_q  <= event_time_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_threshold_q  <= MOVE_THRESHOLD_RST;
			long_press_time_q <= LONG_PRESS_TIME_RST;
			double_tap_time_q <= DOUBLE_TAP_TIME_RST;
			area_width_q      <= AREA_WIDTH_RST;
			swipe_distance_q  <= SWIPE_DISTANCE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MOVE_THRESHOLD:  move_threshold_q  <= cfg_data[7:0];
				CFG_LONG_PRESS_TIME: long_press_time_q <= cfg_data;
				CFG_DOUBLE_TAP_TIME: double_tap_time_q <= cfg_data;
				CFG_AREA_WIDTH:      area_width_q      <= cfg_data[8:0];
				CFG_SWIPE_DISTANCE:  swipe_distance_q  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/tgr_checker.sv =====
// ----------------------------------------------------------------------------
// tgr_checker
// port-level checks of the touch gesture recognizer
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_checker import tgr_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    sample_ready,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result_data
);

	// a stalled result stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// input side stalls only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> result_valid)
		else $error("sample request refused with no result pending");

	// an idle event carries an empty point and no rectangle
	a_none_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.event_kind == EV_NONE |->
			result_data.point_x == '0 && result_data.point_y == '0 &&
			result_data.origin_x == '0 && result_data.origin_y == '0 &&
			result_data.area_hit == AREA_NONE)
		else $error("idle event carries data");

	// a hit lies inside the rectangle rows
	a_hit_band: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.area_hit != AREA_NONE |->
			result_data.point_y >= 8'd35 && result_data.point_y < 8'd170)
		else $error("rectangle hit outside rectangle rows");

	// points stay on the display
	a_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_data.point_x <= 9'd319 && result_data.point_y <= 8'd239 &&
			result_data.origin_x <= 9'd319 && result_data.origin_y <= 8'd239)
		else $error("point off the display");

endmodule

bind touch_gesture_recognizer tgr_checker u_tgr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_ready (sample_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_data  (result_data)
);

`default_nettype wire
